// ----- rtl/lpr_pkg.sv -----
// Package for the line point rasterizer.
// Holds the canvas constants, the controller state type and the command/status structs.
// No dependencies.
package lpr_pkg;

  localparam int CANVAS_SIZE = 64;
  localparam int COORD_W     = 6;
  localparam int SPAN_W      = COORD_W + 1;
  localparam int REM_W       = COORD_W + 3;
  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(CANVAS_SIZE - 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lpr_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } lpr_cmd_t;

  typedef struct packed {
    logic last;
  } lpr_status_t;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    clamp_coord = (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

endpackage

// ----- rtl/lpr_ctrl.sv -----
// Controller state machine for the line point rasterizer.
// Drives the stream handshakes and issues load/step commands to lpr_dp.
// Depends on lpr_pkg.
module lpr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  lpr_pkg::lpr_status_t status,
  output lpr_pkg::lpr_cmd_t    cmd
);
  import lpr_pkg::*;

  lpr_state_t state_r;
  lpr_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_tready && status.last && !in_tvalid) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_RUN: begin
        out_tvalid = 1'b1;
        // overlap the next line's load with the transfer of the last point
        in_tready  = out_tready && status.last;
        cmd.load   = out_tready && status.last && in_tvalid;
        cmd.step   = out_tready && !status.last;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/lpr_dp.sv -----
// Datapath for the line point rasterizer.
// Holds the per-axis quotient/remainder DDA accumulators and the step counter.
// Depends on lpr_pkg.
module lpr_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpr_pkg::lpr_cmd_t             cmd,
  input  logic [lpr_pkg::COORD_W-1:0]   start_x,
  input  logic [lpr_pkg::COORD_W-1:0]   start_y,
  input  logic [lpr_pkg::COORD_W-1:0]   end_x,
  input  logic [lpr_pkg::COORD_W-1:0]   end_y,
  output logic [lpr_pkg::COORD_W-1:0]   point_x,
  output logic [lpr_pkg::COORD_W-1:0]   point_y,
  output lpr_pkg::lpr_status_t          status
);
  import lpr_pkg::*;

  logic [COORD_W-1:0]       sx, sy, ex, ey;
  logic signed [SPAN_W-1:0] dx_in, dy_in;
  logic [COORD_W-1:0]       adx, ady, num_in;

  logic [COORD_W-1:0]       qx_r, qy_r, qx_nxt, qy_nxt;
  logic signed [REM_W-1:0]  rx_r, ry_r, rx_nxt, ry_nxt;
  logic signed [SPAN_W-1:0] dx_r, dy_r;
  logic [COORD_W-1:0]       num_r;
  logic [COORD_W-1:0]       cnt_r;
  logic signed [REM_W-1:0]  two_num;
  logic signed [REM_W-1:0]  tx, ty;

  assign sx = clamp_coord(start_x);
  assign sy = clamp_coord(start_y);
  assign ex = clamp_coord(end_x);
  assign ey = clamp_coord(end_y);

  assign dx_in  = $signed({1'b0, ex}) - $signed({1'b0, sx});
  assign dy_in  = $signed({1'b0, ey}) - $signed({1'b0, sy});
  assign adx    = (ex > sx) ? (ex - sx) : (sx - ex);
  assign ady    = (ey > sy) ? (ey - sy) : (sy - ey);
  assign num_in = (adx >= ady) ? adx : ady;

  assign two_num = $signed({2'b00, num_r, 1'b0});
  assign tx = rx_r + $signed({{(REM_W-SPAN_W-1){dx_r[SPAN_W-1]}}, dx_r, 1'b0});
  assign ty = ry_r + $signed({{(REM_W-SPAN_W-1){dy_r[SPAN_W-1]}}, dy_r, 1'b0});

  always_comb begin
    qx_nxt = qx_r;
    rx_nxt = tx;
    if (tx < 0) begin
      rx_nxt = tx + two_num;
      qx_nxt = qx_r - COORD_W'(1);
    end else if (tx >= two_num) begin
      rx_nxt = tx - two_num;
      qx_nxt = qx_r + COORD_W'(1);
    end
  end

  always_comb begin
    qy_nxt = qy_r;
    ry_nxt = ty;
    if (ty < 0) begin
      ry_nxt = ty + two_num;
      qy_nxt = qy_r - COORD_W'(1);
    end else if (ty >= two_num) begin
      ry_nxt = ty - two_num;
      qy_nxt = qy_r + COORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      num_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
      num_r <= num_in;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + COORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qx_r <= sx;
      qy_r <= sy;
      rx_r <= $signed({{(REM_W-COORD_W){1'b0}}, num_in});
      ry_r <= $signed({{(REM_W-COORD_W){1'b0}}, num_in});
      dx_r <= dx_in;
      dy_r <= dy_in;
    end else if (cmd.step) begin
      qx_r <= qx_nxt;
      qy_r <= qy_nxt;
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
    end
  end

  assign point_x     = qx_r;
  assign point_y     = qy_r;
  assign status.last = (cnt_r == num_r);

endmodule

// ----- rtl/line_point_rasterizer.sv -----
// Top level of the line point rasterizer: stream ports around lpr_ctrl and lpr_dp.
// Depends on lpr_pkg, lpr_ctrl and lpr_dp.
//
// Each input transfer carries two end points; the block then emits one output
// transfer per line point, num+1 of them (1 to 64) where num is the larger of
// the absolute x and y spans, with out_tlast on the final point. Points come at
// one per cycle while the output does not stall, from a pair of quotient/remainder
// accumulators stepped once per output transfer. The next input is taken in
// the same cycle as the last point's transfer, so lines follow each other
// without a gap.
module line_point_rasterizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // point_x[5:0], point_y[11:6], zero[15:12]
  output logic        out_tlast   // last_point
);
  import lpr_pkg::*;

  lpr_cmd_t           cmd;
  lpr_status_t        status;
  logic [COORD_W-1:0] point_x, point_y;

  lpr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  lpr_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .start_x (in_tdata[5:0]),
    .start_y (in_tdata[11:6]),
    .end_x   (in_tdata[17:12]),
    .end_y   (in_tdata[23:18]),
    .point_x (point_x),
    .point_y (point_y),
    .status  (status)
  );

  assign out_tdata = {4'b0000, point_y, point_x};
  assign out_tlast = status.last;

endmodule
